/* rtl/b64d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned SextetW = 6;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned QDepth  = 4;
    localparam int unsigned QPtrW   = $clog2(QDepth);
    localparam int unsigned QCntW   = $clog2(QDepth + 1);

    localparam logic [CharW-1:0] PadChar = 8'h3D;

    localparam logic [1:0] NumOne   = 2'd1;
    localparam logic [1:0] NumThree = 2'd3;

    // one entry of the queue: all results caused by one input item
    typedef struct packed {
        logic [2:0][ByteW-1:0] bytes;
        logic [1:0]            num;
        logic                  present;
        logic                  fin;
    } b64d_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } b64d_qstat_t;

    // returns {valid, sextet}
    function automatic logic [SextetW:0] sextet_decode(input logic [CharW-1:0] c);
        logic [SextetW:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic [2:0][ByteW-1:0] group_bytes(
        input logic [SextetW-1:0] s0,
        input logic [SextetW-1:0] s1,
        input logic [SextetW-1:0] s2,
        input logic [SextetW-1:0] s3
    );
        logic [2:0][ByteW-1:0] b;
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = {s2[1:0], s3};
        return b;
    endfunction

endpackage

/* rtl/b64d_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and builds one queue entry per item
// that gives results.
// ----------------------------------------------------------------------------
module b64d_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [b64d_pkg::CharW-1:0]    s_tdata,   // [7:0] char_code
    input  logic                          s_tlast,   // final_char
    input  b64d_pkg::b64d_qstat_t         q_stat,
    output logic                          job_push,
    output b64d_pkg::b64d_job_t           job
);
    import b64d_pkg::*;

    logic [2:0][SextetW-1:0] buf_reg;
    logic [2:0][SextetW-1:0] buf_next;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic                    pad_reg;
    logic                    pad_next;

    logic                    accept;
    logic [SextetW:0]        dec;
    logic                    grp;
    logic [SextetW-1:0]      fs1;
    logic [SextetW-1:0]      fs2;
    logic [2:0][ByteW-1:0]   fb;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign dec      = sextet_decode(s_tdata);

    always_comb
    begin
        buf_next   = buf_reg;
        count_next = count_reg;
        pad_next   = pad_reg;
        grp        = 1'b0;
        job        = '0;
        job_push   = 1'b0;
        fs1        = '0;
        fs2        = '0;
        fb         = '0;
        if (accept)
        begin
            if (!pad_reg)
            begin
                if (s_tdata == PadChar)
                begin
                    pad_next = 1'b1;
                end
                else if (dec[SextetW])
                begin
                    if (count_reg == NumThree)
                    begin
                        job.bytes   = group_bytes(buf_reg[0], buf_reg[1], buf_reg[2],
                                                  dec[SextetW-1:0]);
                        job.num     = NumThree;
                        job.present = 1'b1;
                        grp         = 1'b1;
                        count_next  = '0;
                    end
                    else
                    begin
                        buf_next[count_reg] = dec[SextetW-1:0];
                        count_next          = count_reg + 2'd1;
                    end
                end
            end
            if (s_tlast)
            begin
                // partial group, missing sextets taken as zero
                fs1 = (count_next >= 2'd2) ? buf_next[1] : '0;
                fs2 = (count_next == NumThree) ? buf_next[2] : '0;
                fb  = group_bytes(buf_next[0], fs1, fs2, '0);
                job.fin = 1'b1;
                if (!grp)
                begin
                    if (count_next >= 2'd2)
                    begin
                        job.bytes   = fb;
                        job.num     = count_next - 2'd1;
                        job.present = 1'b1;
                    end
                    else
                    begin
                        // empty end marker
                        job.bytes   = '0;
                        job.num     = NumOne;
                        job.present = 1'b0;
                    end
                end
                count_next = '0;
                pad_next   = 1'b0;
            end
            job_push = grp || s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pad_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pad_reg   <= pad_next;
        end
    end

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (count_reg == '0 && !pad_reg))
        else $error("state not cleared after final item");

    a_push_num: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.num != '0 && (job.present || job.fin)))
        else $error("bad queue entry");

endmodule

/* rtl/b64d_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64d_pkg::b64d_job_t   push_job,
    input  logic                  pop,
    output b64d_pkg::b64d_job_t   head_job,
    output b64d_pkg::b64d_qstat_t stat
);
    import b64d_pkg::*;

    b64d_job_t              mem_reg [QDepth];
    logic [QPtrW-1:0]       wr_ptr_reg;
    logic [QPtrW-1:0]       wr_ptr_next;
    logic [QPtrW-1:0]       rd_ptr_reg;
    logic [QPtrW-1:0]       rd_ptr_next;
    logic [QCntW-1:0]       count_reg;
    logic [QCntW-1:0]       count_next;
    logic                   do_push;
    logic                   do_pop;

    assign stat.full  = (count_reg == QCntW'(QDepth));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCntW'(do_push) - QCntW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QDepth))
        else $error("queue count overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.empty || stat.full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers inconsistent");

endmodule

/* rtl/b64d_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Takes queue entries and sends their bytes out one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module b64d_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  b64d_pkg::b64d_job_t          head_job,
    input  b64d_pkg::b64d_qstat_t        q_stat,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [b64d_pkg::ByteW-1:0]   m_tdata,   // [7:0] data_byte
    output logic                         m_tlast,   // run_last
    output logic [1:0]                   m_tuser    // [0] byte_present, [1] message_end
);
    import b64d_pkg::*;

    b64d_job_t  cur_reg;
    b64d_job_t  cur_next;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       last_item;

    assign last_item = (idx_reg == cur_reg.num - 2'd1);
    assign pop       = !q_stat.empty && (!valid_reg || (m_tready && last_item));

    assign m_tvalid   = valid_reg;
    assign m_tdata    = (idx_reg == 2'd2) ? cur_reg.bytes[2] :
                        (idx_reg == 2'd1) ? cur_reg.bytes[1] : cur_reg.bytes[0];
    assign m_tlast    = last_item;
    assign m_tuser[0] = cur_reg.present;
    assign m_tuser[1] = cur_reg.fin && last_item;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            cur_next   = head_job;
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (last_item)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < cur_reg.num))
        else $error("byte index beyond entry");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |=> (valid_reg && $stable(idx_reg)))
        else $error("byte index moved during stall");

endmodule

/* rtl/base64_stream_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder: one character in per item, decoded bytes out.
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one character per item in s_tdata, s_tlast on the
//   last character of the text. characters outside the alphabet are skipped,
//   the first pad character stops decoding until s_tlast.
//   output channel m_*: one decoded byte per item in m_tdata, m_tuser[0]
//   set when a byte is present (clear on the empty end marker), m_tuser[1]
//   on the final item of the message, m_tlast on the last item caused by
//   one input character.
//   throughput: one character per cycle sustained while m_tready is high;
//   the back end sends one byte per cycle, three per group of four characters.
//   an accepted item is first written into the queue; its entry is then
//   loaded into the output register once the back end is free, and its
//   first byte is offered from there.
//   a stalled receiver holds the current item; a four-entry queue keeps the
//   front accepting until it fills, then s_tready drops.
//   reset clears the group count, pad state, queue and output valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [b64d_pkg::CharW-1:0]   s_tdata,   // [7:0] char_code
    input  logic                         s_tlast,   // final_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [b64d_pkg::ByteW-1:0]   m_tdata,   // [7:0] data_byte
    output logic                         m_tlast,   // run_last
    output logic [1:0]                   m_tuser    // [0] byte_present, [1] message_end
);
    import b64d_pkg::*;

    b64d_qstat_t q_stat;
    b64d_job_t   push_job;
    b64d_job_t   head_job;
    logic        job_push;
    logic        job_pop;

    b64d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .job_push (job_push),
        .job      (push_job)
    );

    b64d_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    b64d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (job_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
